>>> hw/rtl/bgfa_pkg.sv
package bgfa_pkg;

  localparam int STORE_BYTES_DEF = 256;
  localparam int MAX_FIELD_BITS  = 64;

  localparam int DATA_W = 64;
  localparam int SIZE_W = 7;
  localparam int OFFS_W = 11;
  localparam int POS_W  = OFFS_W + 1;
  localparam int END_W  = POS_W + 1;
  localparam int IDX_W  = POS_W - 2;
  localparam int BUF_W  = DATA_W + 8;
  localparam int SH_W   = $clog2(BUF_W + 8);
  localparam int CNT_W  = 4;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

endpackage

>>> hw/rtl/bgfa_ram.sv
module bgfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bit_granular_field_access_core.sv
// Bit-addressed field read/write over a byte store of STORE_BYTES bytes. A transaction is
// taken when start is high and busy is low; its result appears on out_read_data and
// out_out_of_range for exactly one cycle with out_valid high, and the receiver cannot stall
// it. A zero-size or out-of-range access gives its result the cycle after it is taken and
// leaves busy low. Any other access touches nb = ceil(((base+pos) mod 8 + size) / 8) bytes,
// 1 to 9, through one byte-wide read/modify/write pipe on the store: busy stays high through
// the run state, which reads the bytes and, on a write, writes them back modified, and the align
// state, which registers the result. After reset the store is cleared one byte per cycle, with
// busy high until that is done; the base offset register may be written at any time through the cfg channel.
module bit_granular_field_access_core #(
  parameter int STORE_BYTES = bgfa_pkg::STORE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [bgfa_pkg::OFFS_W-1:0] in_bit_position,
  input  logic [bgfa_pkg::SIZE_W-1:0] in_access_size,
  input  logic [bgfa_pkg::DATA_W-1:0] in_write_data,
  output logic                        out_valid,
  output logic [bgfa_pkg::DATA_W-1:0] out_read_data,
  output logic                        out_out_of_range,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bgfa_pkg::OFFS_W-1:0] cfg_base_offset
);

  import bgfa_pkg::*;

  localparam int AW        = $clog2(STORE_BYTES);
  localparam int STORE_BITS = STORE_BYTES * 8;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_ALIGN} state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [OFFS_W-1:0]   base_r, base_nxt;
  logic                func_r, func_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    nb_r, nb_nxt;
  logic [CNT_W-1:0]    rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0]    wcnt_r, wcnt_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic [SH_W-1:0]     sh_r, sh_nxt;
  logic [DATA_W-1:0]   fmask_r, fmask_nxt;
  logic [BUF_W-1:0]    wdat_r, wdat_nxt;
  logic [BUF_W-1:0]    msk_r, msk_nxt;
  logic [BUF_W-1:0]    rd_r, rd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                out_oor_r, out_oor_nxt;

  logic                accept;
  logic [SIZE_W-1:0]   sz;
  logic [POS_W-1:0]    pos;
  logic [END_W-1:0]    end_pos;
  logic                oor;
  logic [2:0]          off;
  logic [7:0]          span;
  logic [CNT_W-1:0]    nb;
  logic [DATA_W-1:0]   mask64;
  logic                issue;
  logic [BUF_W-1:0]    shifted;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [7:0]          ram_q;

  bgfa_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_out_of_range = out_oor_r;
  assign accept           = start && !busy;

  // access decode
  always_comb begin
    sz      = (in_access_size > SIZE_W'(MAX_FIELD_BITS)) ? SIZE_W'(MAX_FIELD_BITS) :
              in_access_size;
    pos     = POS_W'(base_r) + POS_W'(in_bit_position);
    end_pos = END_W'(pos) + END_W'(sz);
    oor     = (sz != '0) && (32'(end_pos) > 32'(STORE_BITS));
    off     = pos[2:0];
    span    = 8'(off) + 8'(sz) + 8'd7;
    nb      = span[6:3];
    mask64  = (sz >= SIZE_W'(DATA_W)) ? '1 : ~({DATA_W{1'b1}} << sz[5:0]);
  end

  assign issue   = (state_r == ST_RUN) && (rcnt_r != nb_r);
  assign shifted = rd_r >> sh_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(idx_r + IDX_W'(wcnt_r));
    ram_wdata = (ram_q & ~msk_r[7:0]) | (wdat_r[7:0] & msk_r[7:0]);
    ram_raddr = AW'(idx_r + IDX_W'(rcnt_r));
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == ST_RUN) begin
      ram_we = rvalid_r && (func_r == FUNC_WRITE);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    base_nxt      = base_r;
    func_nxt      = func_r;
    idx_nxt       = idx_r;
    nb_nxt        = nb_r;
    rcnt_nxt      = rcnt_r;
    wcnt_nxt      = wcnt_r;
    rvalid_nxt    = 1'b0;
    sh_nxt        = sh_r;
    fmask_nxt     = fmask_r;
    wdat_nxt      = wdat_r;
    msk_nxt       = msk_r;
    rd_nxt        = rd_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    out_oor_nxt   = out_oor_r;

    if (cfg_valid && cfg_ready) begin
      base_nxt = cfg_base_offset;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if ((sz == '0) || oor) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_oor_nxt   = oor;
          end else begin
            state_nxt = ST_RUN;
            func_nxt  = in_func;
            idx_nxt   = IDX_W'(pos[POS_W-1:3]);
            nb_nxt    = nb;
            rcnt_nxt  = '0;
            wcnt_nxt  = '0;
            sh_nxt    = SH_W'(BUF_W - 8 * int'(nb) + int'(off));
            fmask_nxt = mask64;
            wdat_nxt  = BUF_W'(in_write_data & mask64) << off;
            msk_nxt   = BUF_W'(mask64) << off;
            rd_nxt    = '0;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          rcnt_nxt   = rcnt_r + CNT_W'(1);
          rvalid_nxt = 1'b1;
        end
        if (rvalid_r) begin
          wcnt_nxt = wcnt_r + CNT_W'(1);
          rd_nxt   = {ram_q, rd_r[BUF_W-1:8]};
          wdat_nxt = wdat_r >> 8;
          msk_nxt  = msk_r >> 8;
          if (wcnt_r == nb_r - CNT_W'(1)) begin
            state_nxt = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_oor_nxt   = 1'b0;
        out_data_nxt  = (func_r == FUNC_READ) ? (shifted[DATA_W-1:0] & fmask_r) : '0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      base_r      <= '0;
      rcnt_r      <= '0;
      wcnt_r      <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      base_r      <= base_nxt;
      rcnt_r      <= rcnt_nxt;
      wcnt_r      <= wcnt_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    idx_r      <= idx_nxt;
    nb_r       <= nb_nxt;
    sh_r       <= sh_nxt;
    fmask_r    <= fmask_nxt;
    wdat_r     <= wdat_nxt;
    msk_r      <= msk_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer active");

  a_oor_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_read_data == '0))
    else $error("out of range result carries data");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted transaction dropped");

  a_write_only_for_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && ram_we) |-> (func_r == FUNC_WRITE))
    else $error("store written during read transaction");

  a_consume_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (wcnt_r <= rcnt_r))
    else $error("byte consumed before it was read");

endmodule
